>>> sv/ophts_pkg.sv
// Shared types and constants for the old password hash tail solver.
package ophts_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned TargW  = 31;
  localparam int unsigned CharW  = 8;
  localparam int unsigned QuotW  = 8;

  localparam logic [WordW-1:0] InitFirst  = 32'h5030_5735;
  localparam logic [WordW-1:0] InitSecond = 32'h1234_5671;
  localparam logic [WordW-1:0] InitSum    = 32'd7;
  localparam logic [WordW-1:0] LowMask    = 32'h0000_003f;
  localparam logic [CharW-1:0] CharMinOk  = 8'd33;
  localparam logic [CharW-1:0] CharMaxOk  = 8'd126;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_TEST   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_TARGET_FIRST  = 2'd0,
    REG_TARGET_SECOND = 2'd1
  } reg_index_t;

  typedef struct packed {
    logic             start;
    logic [TargW-1:0] dividend;
    logic [WordW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic             exact;
    logic [QuotW-1:0] quotient;
  } div_status_t;

endpackage

>>> sv/ophts_divider.sv
// Iterative restoring divider producing an eight-bit quotient, one bit per cycle.
module ophts_divider (
  input  logic                   clk,
  input  logic                   rst,
  input  ophts_pkg::div_req_t    req,
  output ophts_pkg::div_status_t status
);
  import ophts_pkg::*;

  localparam int unsigned CntW = $clog2(QuotW + 1);

  logic [WordW-1:0] rem;
  logic [WordW-1:0] divisor;
  logic [QuotW-1:0] low_bits;
  logic [QuotW-1:0] quot;
  logic [CntW-1:0]  count;
  logic             done;

  logic [WordW:0] trial;

  // The caller only starts a division whose quotient fits in eight bits,
  // so the upper dividend bits already sit below the divisor.
  assign trial = {rem, low_bits[QuotW-1]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem      <= {{(WordW - TargW + QuotW){1'b0}}, req.dividend[TargW-1:QuotW]};
        low_bits <= req.dividend[QuotW-1:0];
        divisor  <= req.divisor;
        quot     <= '0;
        count    <= CntW'(QuotW);
      end else if (count != '0) begin
        if (!trial[WordW]) begin
          rem <= trial[WordW-1:0];
        end else begin
          rem <= {rem[WordW-2:0], low_bits[QuotW-1]};
        end
        quot     <= {quot[QuotW-2:0], ~trial[WordW]};
        low_bits <= {low_bits[QuotW-2:0], 1'b0};
        count    <= count - 1'b1;
        if (count == CntW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign status.busy     = (count != '0);
  assign status.done     = done;
  assign status.exact    = (rem == '0);
  assign status.quotient = quot;

endmodule

>>> sv/old_password_hash_tail_solver_top.sv
// Top level of the old password hash tail solver: hash state, sequencer and result register.
//
// Requests arrive on the s_ channel: s_tuser carries the action (clear the
// prefix state, append a prefix character, or test a candidate character)
// and s_tdata the character. Every request gives exactly one result on the
// m_ channel: m_tuser flags a match, m_tdata carries the two solved tail
// characters, both zero when there is no match.
// One request is worked on at a time and s_tready is high only while the
// sequencer is idle. A clear goes from idle straight to the done state, an
// append passes through the hash states, and a candidate test runs the hash
// arithmetic, window checks and then up to two divisions on the one shared
// bit-serial divider, the second of which runs only when the first succeeds.
// The sequencer returns to idle in the same cycle its result is registered.
// The result sits in an output register; if the receiver stalls, the
// sequencer waits with its finished result and takes no new request.
// The target words are written through the cfg_ port; the user must do so
// only while the block is idle, which the block itself does not enforce.
// A synchronous reset restores the initial hash state, clears the targets
// to zero and drops any pending result.
module old_password_hash_tail_solver_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_value
  input  logic [1:0]  s_tuser,   // [1:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] second_char, [15:8] last_char
  output logic        m_tuser,   // [0] found_match
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);
  import ophts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HASH,
    S_S2,
    S_S3,
    S_PREP1,
    S_WIN1,
    S_DIV1,
    S_PREP2,
    S_WIN2,
    S_DIV2,
    S_DONE
  } state_t;

  state_t state;

  logic [TargW-1:0] target_first;
  logic [TargW-1:0] target_second;
  logic [WordW-1:0] first_state;
  logic [WordW-1:0] second_state;
  logic [WordW-1:0] char_sum;

  action_t          action;
  logic [CharW-1:0] ch;
  logic [WordW-1:0] s1;
  logic [WordW-1:0] s2;
  logic [WordW-1:0] s3;
  logic [WordW-1:0] work_div;
  logic [TargW-1:0] work_diff;
  logic [QuotW-1:0] d_char;

  logic             res_found;
  logic [CharW-1:0] res_second;
  logic [CharW-1:0] res_last;
  logic             out_found;
  logic [CharW-1:0] out_second;
  logic [CharW-1:0] out_last;

  div_req_t    div_req;
  div_status_t div_status;

  logic [WordW-1:0] mult;
  logic [WordW-1:0] s1_calc;
  logic [WordW-1:0] s2_calc;
  logic [WordW-1:0] s3_calc;
  logic [WordW-1:0] div1_calc;
  logic [WordW-1:0] diff1_calc;
  logic [WordW-1:0] div2_calc;
  logic [WordW-1:0] diff2_calc;
  logic [WordW-1:0] diff_ext;
  logic             window_ok;
  logic             chars_ok;

  assign mult      = (first_state & LowMask) + char_sum;
  assign s1_calc   = first_state ^ (mult * {{(WordW - CharW){1'b0}}, ch}
                                    + {first_state[WordW-9:0], 8'h00});
  assign s2_calc   = second_state + ({second_state[WordW-9:0], 8'h00} ^ s1);
  assign s3_calc   = ({{(WordW - TargW){1'b0}}, target_second} - s2)
                     ^ {s2[WordW-9:0], 8'h00};
  assign div1_calc = (s1 & LowMask) + char_sum + {{(WordW - CharW){1'b0}}, ch};
  assign diff1_calc = (s3 ^ s1) - {s1[WordW-9:0], 8'h00};
  assign div2_calc = (s3 & LowMask) + char_sum + {{(WordW - CharW){1'b0}}, ch}
                     + {{(WordW - QuotW){1'b0}}, d_char};
  assign diff2_calc = ({{(WordW - TargW){1'b0}}, target_first} ^ s3)
                      - {s3[WordW-9:0], 8'h00};

  // Window tests bound the quotient to below 256, which the divider relies on.
  assign diff_ext  = {{(WordW - TargW){1'b0}}, work_diff};
  assign window_ok = (work_div != '0) && ((diff_ext >> 7) <= work_div)
                     && ((diff_ext >> 5) >= work_div);
  assign chars_ok  = (d_char >= CharMinOk) && (d_char <= CharMaxOk)
                     && (div_status.quotient >= CharMinOk)
                     && (div_status.quotient <= CharMaxOk);

  assign div_req.start    = ((state == S_WIN1) || (state == S_WIN2)) && window_ok;
  assign div_req.dividend = work_diff;
  assign div_req.divisor  = work_div;

  ophts_divider u_divider (
    .clk    (clk),
    .rst    (rst),
    .req    (div_req),
    .status (div_status)
  );

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {out_last, out_second};
  assign m_tuser  = out_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_tvalid      <= 1'b0;
      target_first  <= '0;
      target_second <= '0;
      first_state   <= InitFirst;
      second_state  <= InitSecond;
      char_sum      <= InitSum;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TARGET_FIRST:  target_first  <= cfg_data;
          REG_TARGET_SECOND: target_second <= cfg_data;
          default: ;
        endcase
      end

      // In the done state the output register is reloaded instead.
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            action     <= action_t'(s_tuser);
            ch         <= s_tdata;
            res_found  <= 1'b0;
            res_second <= '0;
            res_last   <= '0;
            case (action_t'(s_tuser))
              ACT_CLEAR: begin
                first_state  <= InitFirst;
                second_state <= InitSecond;
                char_sum     <= InitSum;
                state        <= S_DONE;
              end
              ACT_APPEND, ACT_TEST: state <= S_HASH;
              default: state <= S_DONE;
            endcase
          end
        end
        S_HASH: begin
          s1    <= s1_calc;
          state <= S_S2;
        end
        S_S2: begin
          if (action == ACT_APPEND) begin
            first_state  <= s1;
            second_state <= s2_calc;
            char_sum     <= char_sum + {{(WordW - CharW){1'b0}}, ch};
            state        <= S_DONE;
          end else begin
            s2    <= s2_calc;
            state <= S_S3;
          end
        end
        S_S3: begin
          s3    <= s3_calc;
          state <= S_PREP1;
        end
        S_PREP1: begin
          work_div  <= div1_calc;
          work_diff <= diff1_calc[TargW-1:0];
          state     <= S_WIN1;
        end
        S_WIN1: begin
          state <= window_ok ? S_DIV1 : S_DONE;
        end
        S_DIV1: begin
          if (div_status.done) begin
            d_char <= div_status.quotient;
            state  <= div_status.exact ? S_PREP2 : S_DONE;
          end
        end
        S_PREP2: begin
          work_div  <= div2_calc;
          work_diff <= diff2_calc[TargW-1:0];
          state     <= S_WIN2;
        end
        S_WIN2: begin
          state <= window_ok ? S_DIV2 : S_DONE;
        end
        S_DIV2: begin
          if (div_status.done) begin
            if (div_status.exact && chars_ok) begin
              res_found  <= 1'b1;
              res_second <= d_char;
              res_last   <= div_status.quotient;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_found  <= res_found;
            out_second <= res_second;
            out_last   <= res_last;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A reported match always carries printable characters.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[7:0] >= CharMinOk && m_tdata[7:0] <= CharMaxOk
                               && m_tdata[15:8] >= CharMinOk && m_tdata[15:8] <= CharMaxOk))
    else $error("match reported with a character outside the printable range");

  // Without a match both character fields are zero.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("non-match result carries character data");

  // The divider is never busy while a new request may be accepted.
  assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !div_status.busy)
    else $error("divider busy while the sequencer is idle");

  // A division finishes only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    div_status.done |-> (state == S_DIV1 || state == S_DIV2))
    else $error("divider finished outside a division state");

  // Every division that is started reports its completion on the done flag.
  assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> ##9 div_status.done)
    else $error("divider did not finish in the expected number of cycles");

endmodule
